>>> design/llti_pkg.sv
// shared constants, breakpoint tables and helper types for the log-log drag table unit
`timescale 1ns / 1ps
package llti_pkg;

    localparam int TABLE_POINTS_DEF = 23;
    localparam int ROM_DEFINED      = 22;
    localparam int ROM_AW           = 5;
    localparam int LOG_W            = 23;   // signed Q6.16
    localparam int DIFF_W           = 24;
    localparam int PROD_W           = 48;
    localparam int MAG_W            = 47;
    localparam int QUOT_W           = 24;
    localparam int Y_W              = 25;
    localparam int STEPS            = 16;
    localparam int COEFF_W          = 23;
    localparam logic [COEFF_W-1:0] OUT_MAX = 23'h7FFFFF;

    localparam logic [1:0] REGION_INTERP = 2'd0;
    localparam logic [1:0] REGION_BELOW  = 2'd1;
    localparam logic [1:0] REGION_ABOVE  = 2'd2;

    typedef struct packed {
        logic              start;
        logic [MAG_W-1:0]  num;
        logic [LOG_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

    // elaboration-time only: log2 in Q16 with the fraction truncated
    function automatic logic signed [31:0] log2_q16(input logic [31:0] v);
        logic [63:0] m;
        logic [31:0] frac;
        int p;
        p    = 0;
        frac = '0;
        for (int j = 0; j < 32; j++) begin
            if (v[j]) p = j;
        end
        m = 64'(v) << (31 - p);
        for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000) begin
                frac[15-k] = 1'b1;
                m = m >> 1;
            end
        end
        return 32'(p * 65536) + frac;
    endfunction

    function automatic logic signed [LOG_W-1:0] lq(input logic [31:0] n, input logic [31:0] d);
        return LOG_W'(log2_q16(n) - log2_q16(d));
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] x;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        x = v;
        for (int j = 0; j < 32; j++) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // root 2^(2^-k) in Q2.30
    function automatic logic [31:0] pow_root(input int k);
        logic [63:0] root;
        root = 64'h8000_0000;
        for (int j = 1; j <= k; j++) begin
            root = isqrt64(root << 30);
        end
        return root[31:0];
    endfunction

    localparam logic signed [LOG_W-1:0] LX [ROM_DEFINED] = '{
        lq(1, 5), lq(1, 2), lq(1, 1), lq(2, 1), lq(5, 1), lq(10, 1), lq(20, 1),
        lq(50, 1), lq(100, 1), lq(200, 1), lq(500, 1), lq(1000, 1), lq(2000, 1),
        lq(5000, 1), lq(10000, 1), lq(20000, 1), lq(50000, 1), lq(100000, 1),
        lq(200000, 1), lq(240000, 1), lq(400000, 1), lq(600000, 1)
    };

    localparam logic signed [LOG_W-1:0] LY [ROM_DEFINED] = '{
        lq(100, 1), lq(45, 1), lq(30, 1), lq(29, 2), lq(15, 2), lq(31, 5), lq(21, 5),
        lq(3, 2), lq(1, 1), lq(3, 4), lq(11, 20), lq(9, 20), lq(3, 10), lq(37, 100),
        lq(2, 5), lq(47, 100), lq(1, 2), lq(47, 100), lq(17, 40), lq(1, 8),
        lq(7, 40), lq(1, 5)
    };

    // coefficients rounded to UQ7.16
    localparam logic [COEFF_W-1:0] CD [ROM_DEFINED] = '{
        23'd6553600, 23'd2949120, 23'd1966080, 23'd950272, 23'd491520, 23'd406323,
        23'd275251, 23'd98304, 23'd65536, 23'd49152, 23'd36045, 23'd29491,
        23'd19661, 23'd24248, 23'd26214, 23'd30802, 23'd32768, 23'd30802,
        23'd27853, 23'd8192, 23'd11469, 23'd13107
    };

    localparam logic [31:0] ROOT [STEPS] = '{
        pow_root(1), pow_root(2), pow_root(3), pow_root(4), pow_root(5), pow_root(6),
        pow_root(7), pow_root(8), pow_root(9), pow_root(10), pow_root(11),
        pow_root(12), pow_root(13), pow_root(14), pow_root(15), pow_root(16)
    };

endpackage

>>> design/llti_div.sv
// restoring divider, one quotient bit per cycle, for the log-space interpolation
`timescale 1ns / 1ps
module llti_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  llti_pkg::t_div_req i_req,
    output llti_pkg::t_div_rsp o_rsp
);

    localparam int CW = $clog2(llti_pkg::QUOT_W);

    logic                          r_busy;
    logic                          r_done;
    logic [CW-1:0]                 r_cnt;
    logic [llti_pkg::MAG_W-1:0]    r_rem;
    logic [llti_pkg::MAG_W-1:0]    r_dsh;
    logic [llti_pkg::QUOT_W-1:0]   r_quot;
    logic                          w_ge;

    assign w_ge = r_rem >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(llti_pkg::QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.num;
            r_dsh  <= llti_pkg::MAG_W'(i_req.den) << (llti_pkg::QUOT_W - 1);
            r_quot <= '0;
        end else if (r_busy) begin
            if (w_ge) r_rem <= r_rem - r_dsh;
            r_quot <= {r_quot[llti_pkg::QUOT_W-2:0], w_ge};
            r_dsh  <= r_dsh >> 1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

>>> design/log_log_table_interpolator_unit.sv
// sphere drag coefficient from reynolds number by log-log table interpolation
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+-------------------------------
//  input   | i_in_valid  | o_in_ready  | i_reynolds (UQ24.8)
//  output  | o_out_valid | i_out_ready | o_drag_coeff (UQ7.16), o_region
//
// one transaction at a time: every input passes 5 normalize steps and 16 log squarings;
// an interpolated one then takes the rom probes of a binary search, a 24-bit divide and
// 16 power products. the log squarings and power products share one 32x32 multiplier.
// the breakpoint rom has a registered read, one address per cycle.
// reset is synchronous and needs no clearing pass; a result waiting on a stalled
// output does not block the next input transaction until it is ready to retire.
`timescale 1ns / 1ps
module log_log_table_interpolator_unit #(
    parameter int TABLE_POINTS = llti_pkg::TABLE_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [31:0]                   i_reynolds,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [llti_pkg::COEFF_W-1:0]  o_drag_coeff,
    output logic [1:0]                    o_region
);

    localparam int N_EFF = (TABLE_POINTS < 2) ? 2 :
                           ((TABLE_POINTS > llti_pkg::ROM_DEFINED) ?
                            llti_pkg::ROM_DEFINED : TABLE_POINTS);
    localparam int AW = llti_pkg::ROM_AW;
    localparam logic [AW-1:0] LAST = AW'(N_EFF - 1);
    localparam int LW = llti_pkg::LOG_W;
    localparam int DW = llti_pkg::DIFF_W;
    localparam int YW = llti_pkg::Y_W;

    typedef enum logic [3:0] {
        S_IDLE, S_NORM, S_LOG, S_CHK, S_PROBE, S_CMP, S_RDL, S_RDR,
        S_DIFF, S_MUL, S_DIVS, S_DIVW, S_POW, S_RND, S_DONE
    } t_state;

    t_state                         r_state;
    logic                           r_re_zero;
    logic [31:0]                    r_m;
    logic [4:0]                     r_z;
    logic [15:0]                    r_frac;
    logic [3:0]                     r_cnt;
    logic [AW-1:0]                  r_left;
    logic [AW-1:0]                  r_right;
    logic signed [LW-1:0]           r_rom_lx;
    logic signed [LW-1:0]           r_rom_ly;
    logic signed [LW-1:0]           r_lxl;
    logic signed [LW-1:0]           r_lyl;
    logic signed [DW-1:0]           r_dx;
    logic signed [DW-1:0]           r_dy;
    logic signed [DW-1:0]           r_den;
    logic signed [llti_pkg::PROD_W-1:0] r_prod;
    logic signed [YW-1:0]           r_y;
    logic [31:0]                    r_acc;
    logic [llti_pkg::COEFF_W-1:0]   r_res_coeff;
    logic [1:0]                     r_res_region;
    logic                           r_out_valid;
    logic [llti_pkg::COEFF_W-1:0]   r_drag;
    logic [1:0]                     r_region;

    logic [31:0]                    w_ma;
    logic [31:0]                    w_mb;
    logic [63:0]                    w_mul;
    logic [32:0]                    w_sq;
    logic [4:0]                     w_sh;
    logic                           w_top_zero;
    logic signed [6:0]              w_lint;
    logic signed [LW-1:0]           w_l;
    logic [AW-1:0]                  w_mid;
    logic [AW-1:0]                  w_nl;
    logic [AW-1:0]                  w_nr;
    logic [AW-1:0]                  w_addr;
    logic [llti_pkg::PROD_W-1:0]    w_mag;
    logic signed [YW-1:0]           w_qs;
    logic [15:0]                    w_fy;
    logic signed [8:0]              w_i;
    logic signed [9:0]              w_s;
    logic [39:0]                    w_rnd;
    logic [llti_pkg::COEFF_W-1:0]   w_pow;
    logic                           w_retire;
    llti_pkg::t_div_req             w_div_req;
    llti_pkg::t_div_rsp             w_div_rsp;

    // one multiplier shared by the log squarings and the power products
    assign w_ma  = (r_state == S_POW) ? r_acc : r_m;
    assign w_mb  = (r_state == S_POW) ? llti_pkg::ROOT[r_cnt] : r_m;
    assign w_mul = w_ma * w_mb;
    assign w_sq  = w_mul[63:31];

    assign w_sh       = 5'(5'd16 >> r_cnt);
    assign w_top_zero = (r_m >> (6'd32 - {1'b0, w_sh})) == 32'd0;

    assign w_lint = 7'sd23 - $signed({2'b00, r_z});
    assign w_l    = $signed({w_lint, r_frac});

    assign w_mid = AW'(({1'b0, r_left} + {1'b0, r_right}) >> 1);
    assign w_nl  = (w_l > r_rom_lx) ? w_mid : r_left;
    assign w_nr  = (w_l > r_rom_lx) ? r_right : w_mid;

    always_comb begin
        unique case (r_state)
            S_PROBE: w_addr = w_mid;
            S_RDR:   w_addr = r_right;
            default: w_addr = r_left;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rom_lx <= llti_pkg::LX[w_addr];
        r_rom_ly <= llti_pkg::LY[w_addr];
    end

    assign w_mag = r_prod[llti_pkg::PROD_W-1] ? llti_pkg::PROD_W'(-r_prod)
                                              : llti_pkg::PROD_W'(r_prod);
    assign w_div_req.start = (r_state == S_DIVS);
    assign w_div_req.num   = w_mag[llti_pkg::MAG_W-1:0];
    assign w_div_req.den   = r_den[LW-1:0];

    llti_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_div_req),
        .o_rsp  (w_div_rsp)
    );

    assign w_qs = $signed({1'b0, w_div_rsp.quot});
    assign w_fy = r_y[15:0];

    // floor of y, then the right shift that brings Q2.30 to UQ7.16
    assign w_i   = r_y[YW-1:16];
    assign w_s   = 10'sd14 - 10'(w_i);
    assign w_rnd = ({8'd0, r_acc} + (40'd1 << (w_s[5:0] - 6'd1))) >> w_s[5:0];

    always_comb begin
        priority if (w_i >= 9'sd14) begin
            w_pow = llti_pkg::OUT_MAX;
        end else if (w_s >= 10'sd40) begin
            w_pow = '0;
        end else if (w_rnd > 40'(llti_pkg::OUT_MAX)) begin
            w_pow = llti_pkg::OUT_MAX;
        end else begin
            w_pow = w_rnd[llti_pkg::COEFF_W-1:0];
        end
    end

    // result moves to the output register when it is empty or draining
    assign w_retire = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_retire) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_m       <= i_reynolds;
                        r_re_zero <= (i_reynolds == 32'd0);
                        r_z       <= '0;
                        r_cnt     <= '0;
                        r_state   <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (w_top_zero) begin
                        r_m <= r_m << w_sh;
                        r_z <= r_z + w_sh;
                    end
                    if (r_cnt == 4'd4) begin
                        r_cnt   <= '0;
                        r_frac  <= '0;
                        r_state <= S_LOG;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_LOG: begin
                    r_frac[4'd15 - r_cnt] <= w_sq[32];
                    r_m   <= w_sq[32] ? w_sq[32:1] : w_sq[31:0];
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'd15) r_state <= S_CHK;
                end
                S_CHK: begin
                    r_left  <= '0;
                    r_right <= LAST;
                    priority if (r_re_zero || w_l < llti_pkg::LX[0]) begin
                        r_res_coeff  <= llti_pkg::CD[0];
                        r_res_region <= llti_pkg::REGION_BELOW;
                        r_state      <= S_DONE;
                    end else if (w_l > llti_pkg::LX[LAST]) begin
                        r_res_coeff  <= llti_pkg::CD[LAST];
                        r_res_region <= llti_pkg::REGION_ABOVE;
                        r_state      <= S_DONE;
                    end else if (LAST > AW'(1)) begin
                        r_state <= S_PROBE;
                    end else begin
                        r_state <= S_RDL;
                    end
                end
                S_PROBE: r_state <= S_CMP;
                S_CMP: begin
                    r_left  <= w_nl;
                    r_right <= w_nr;
                    r_state <= (w_nr - w_nl > AW'(1)) ? S_PROBE : S_RDL;
                end
                S_RDL: r_state <= S_RDR;
                S_RDR: begin
                    r_lxl   <= r_rom_lx;
                    r_lyl   <= r_rom_ly;
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_dx    <= DW'(w_l) - DW'(r_lxl);
                    r_dy    <= DW'(r_rom_ly) - DW'(r_lyl);
                    r_den   <= DW'(r_rom_lx) - DW'(r_lxl);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod <= r_dx * r_dy;
                    r_cnt  <= '0;
                    r_acc  <= 32'h4000_0000;
                    // empty segment takes the left coefficient
                    if (r_den[DW-1] || r_den == '0) begin
                        r_y     <= YW'(r_lyl);
                        r_state <= S_POW;
                    end else begin
                        r_state <= S_DIVS;
                    end
                end
                S_DIVS: r_state <= S_DIVW;
                S_DIVW: begin
                    if (w_div_rsp.done) begin
                        r_y     <= YW'(r_lyl) + (r_dy[DW-1] ? -w_qs : w_qs);
                        r_state <= S_POW;
                    end
                end
                S_POW: begin
                    if (w_fy[4'd15 - r_cnt]) r_acc <= w_mul[61:30];
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'd15) r_state <= S_RND;
                end
                S_RND: begin
                    r_res_coeff  <= w_pow;
                    r_res_region <= llti_pkg::REGION_INTERP;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    if (w_retire) begin
                        r_drag   <= r_res_coeff;
                        r_region <= r_res_region;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_drag_coeff = r_drag;
    assign o_region     = r_region;

endmodule

>>> design/llti_checker.sv
// port-level assertions for the log-log drag table unit, bound to the top level
`timescale 1ns / 1ps
module llti_checker #(
    parameter int TABLE_POINTS = llti_pkg::TABLE_POINTS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic [31:0]                  i_reynolds,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [llti_pkg::COEFF_W-1:0] o_drag_coeff,
    input logic [1:0]                   o_region
);

    localparam int N_EFF = (TABLE_POINTS < 2) ? 2 :
                           ((TABLE_POINTS > llti_pkg::ROM_DEFINED) ?
                            llti_pkg::ROM_DEFINED : TABLE_POINTS);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_drag_coeff)
                                        && $stable(o_region))
        else $error("result changed while stalled");

    // clamped results carry the end coefficients
    a_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_region == llti_pkg::REGION_BELOW |->
            o_drag_coeff == llti_pkg::CD[0])
        else $error("below-table result is not the first coefficient");

    a_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_region == llti_pkg::REGION_ABOVE |->
            o_drag_coeff == llti_pkg::CD[N_EFF-1])
        else $error("above-table result is not the last coefficient");

    // one transaction in flight: intake closes right after acceptance
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_reynolds == i_reynolds |=> !o_in_ready)
        else $error("second transaction taken while one is in flight");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind log_log_table_interpolator_unit llti_checker #(.TABLE_POINTS(TABLE_POINTS)) u_checker (.*);

>>> test/tb_log_log_table_interpolator_unit.sv
// self-checking testbench for the log-log drag table unit with random handshake idling
`timescale 1ns / 1ps
module tb_log_log_table_interpolator_unit;

    localparam int  N_RANDOM    = 1180;
    localparam int  CYCLE_LIMIT = 1500000;
    localparam int  BP_COUNT    = 22;

    typedef struct packed {
        logic [llti_pkg::COEFF_W-1:0] drag_coeff;
        logic [1:0]                   region;
    } t_drag_res;

    typedef struct packed {
        logic        drain_first;
        logic [31:0] reynolds;
    } t_re_item;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_ready;
    logic [31:0]                  i_reynolds;
    logic                         o_out_valid;
    logic                         i_out_ready;
    logic [llti_pkg::COEFF_W-1:0] o_drag_coeff;
    logic [1:0]                   o_region;

    t_re_item  re_pending[$];
    t_drag_res drag_expected[$];
    int        mismatch_count;
    int        cycle_count;
    bit        stim_done;

    longint unsigned re_n [BP_COUNT] = '{1, 1, 1, 2, 5, 10, 20, 50, 100, 200, 500, 1000,
        2000, 5000, 10000, 20000, 50000, 100000, 200000, 240000, 400000, 600000};
    longint unsigned re_d [BP_COUNT] = '{5, 2, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
        1, 1, 1, 1, 1, 1, 1, 1, 1, 1};
    longint unsigned cd_n [BP_COUNT] = '{100, 45, 30, 29, 15, 31, 21, 3, 1, 3, 11, 9,
        3, 37, 2, 47, 1, 47, 17, 1, 7, 1};
    longint unsigned cd_d [BP_COUNT] = '{1, 1, 1, 2, 2, 5, 5, 2, 1, 4, 20, 20,
        10, 100, 5, 100, 2, 100, 40, 8, 40, 5};

    log_log_table_interpolator_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_reynolds   (i_reynolds),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_drag_coeff (o_drag_coeff),
        .o_region     (o_region)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // log2 in Q16, fraction from 16 truncated squarings
    function automatic longint log2_fix(input longint unsigned v);
        longint unsigned m;
        longint          frac;
        int              p;
        p    = 0;
        frac = 0;
        if (v == 0) return 0;
        for (int j = 0; j < 64; j++) begin
            if (v[j]) p = j;
        end
        if (p <= 31) m = v << (31 - p);
        else m = v >> (p - 31);
        for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000) begin
                frac = frac | (longint'(1) << (15 - k));
                m = m >> 1;
            end
        end
        return longint'(p) * 65536 + frac;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^y with y in Q16, rounded half up to UQ7.16 and saturated
    function automatic logic [llti_pkg::COEFF_W-1:0] exp2_fix(input longint y);
        longint          yo;
        longint unsigned acc;
        longint unsigned root;
        longint          ip;
        longint          f;
        int              s;
        yo   = y + 64 * 65536;
        acc  = 64'd1 << 30;
        root = 64'd2 << 30;
        if (yo < 0) return '0;
        ip = (yo >>> 16) - 64;
        f  = yo & 16'hFFFF;
        if (ip >= 14) return llti_pkg::OUT_MAX;
        for (int k = 1; k <= 16; k++) begin
            root = int_sqrt(root << 30);
            if (((f >> (16 - k)) & 1) != 0) acc = (acc * root) >> 30;
        end
        s = 14 - int'(ip);
        if (s >= 40) return '0;
        acc = (acc + (64'd1 << (s - 1))) >> s;
        return (acc > llti_pkg::OUT_MAX) ? llti_pkg::OUT_MAX : acc[llti_pkg::COEFF_W-1:0];
    endfunction

    function automatic longint bp_log_re(input int i);
        return log2_fix(re_n[i]) - log2_fix(re_d[i]);
    endfunction

    function automatic longint bp_log_cd(input int i);
        return log2_fix(cd_n[i]) - log2_fix(cd_d[i]);
    endfunction

    function automatic logic [llti_pkg::COEFF_W-1:0] bp_coeff(input int i);
        longint unsigned v;
        v = (cd_n[i] * 65536 + cd_d[i] / 2) / cd_d[i];
        return (v > llti_pkg::OUT_MAX) ? llti_pkg::OUT_MAX : v[llti_pkg::COEFF_W-1:0];
    endfunction

    function automatic t_drag_res drag_of_reynolds(input logic [31:0] re);
        t_drag_res r;
        int        n;
        int        lo;
        int        hi;
        int        mid;
        longint    lg;
        longint    den;
        longint    y;
        n  = (llti_pkg::TABLE_POINTS_DEF > BP_COUNT) ? BP_COUNT
                                                     : llti_pkg::TABLE_POINTS_DEF;
        lg = log2_fix(re) - 8 * 65536;
        if (re == 0 || lg < bp_log_re(0)) begin
            r.drag_coeff = bp_coeff(0);
            r.region     = llti_pkg::REGION_BELOW;
            return r;
        end
        if (lg > bp_log_re(n - 1)) begin
            r.drag_coeff = bp_coeff(n - 1);
            r.region     = llti_pkg::REGION_ABOVE;
            return r;
        end
        lo = 0;
        hi = n - 1;
        while (lo < hi - 1) begin
            mid = (lo + hi) / 2;
            if (lg > bp_log_re(mid)) lo = mid;
            else hi = mid;
        end
        den = bp_log_re(hi) - bp_log_re(lo);
        if (den <= 0) y = bp_log_cd(lo);
        else y = bp_log_cd(lo)
                 + ((lg - bp_log_re(lo)) * (bp_log_cd(hi) - bp_log_cd(lo))) / den;
        y = longint'(int'(y));
        r.drag_coeff = exp2_fix(y);
        r.region     = llti_pkg::REGION_INTERP;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    function automatic bit idle_now();
        // quiet stretch with no idling
        if (cycle_count > 20000 && cycle_count < 40000) return 1'b0;
        return $urandom_range(0, 99) < 13;
    endfunction

    // driver
    always @(posedge i_clk) begin
        logic        nxt_valid;
        logic [31:0] nxt_re;
        nxt_valid = i_in_valid;
        nxt_re    = i_reynolds;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                drag_expected.push_back(drag_of_reynolds(i_reynolds));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && re_pending.size() != 0 && !idle_now()) begin
                if (!(re_pending[0].drain_first && drag_expected.size() != 0)) begin
                    nxt_valid = 1'b1;
                    nxt_re    = re_pending[0].reynolds;
                    void'(re_pending.pop_front());
                end
            end
        end
        i_in_valid <= nxt_valid;
        i_reynolds <= nxt_re;
    end

    // monitor
    always @(posedge i_clk) begin
        t_drag_res got;
        t_drag_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.drag_coeff = o_drag_coeff;
            got.region     = o_region;
            if (drag_expected.size() == 0) begin
                report_mismatch("result transaction with nothing expected");
            end else begin
                want = drag_expected.pop_front();
                if (got.drag_coeff !== want.drag_coeff)
                    report_mismatch($sformatf("drag_coeff %0d expected %0d",
                        got.drag_coeff, want.drag_coeff));
                if (got.region !== want.region)
                    report_mismatch($sformatf("region %0d expected %0d",
                        got.region, want.region));
            end
        end
        i_out_ready <= i_rst_n ? !idle_now() : 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("log_log_table_interpolator_unit regression: fail");
            $finish;
        end
    end

    task automatic add_item(input logic [31:0] re, input bit drain);
        t_re_item it;
        it.reynolds    = re;
        it.drain_first = drain;
        re_pending.push_back(it);
    endtask

    initial begin
        logic [31:0] v;
        int          sh;
        mismatch_count = 0;
        cycle_count    = 0;
        i_in_valid     = 1'b0;
        i_reynolds     = '0;
        i_out_ready    = 1'b0;
        i_rst_n        = 1'b0;
        // zero, tiny, around the first and last breakpoints, extremes
        add_item(32'd0, 0);
        add_item(32'd1, 0);
        add_item(32'd2, 0);
        add_item(32'd51, 0);
        add_item(32'd52, 0);
        add_item(32'd127, 0);
        add_item(32'd128, 0);
        add_item(32'd256, 0);
        add_item(32'd512, 0);
        add_item(32'd1280, 0);
        add_item(32'd25600, 0);
        add_item(32'd1280000, 0);
        add_item(32'd25600000, 0);
        add_item(32'd61440000, 0);
        add_item(32'd61440001, 0);
        add_item(32'd102400000, 0);
        add_item(32'd153599999, 0);
        add_item(32'd153600000, 0);
        add_item(32'd153600001, 0);
        add_item(32'h8000_0000, 0);
        add_item(32'hFFFF_FFFF, 0);
        add_item(32'h5555_5555, 0);
        add_item(32'hAAAA_AAAA, 0);
        for (int n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(0, 99) < 80) begin
                sh = $urandom_range(0, 31);
                v  = {1'b1, 31'($urandom)} >> (31 - sh);
            end else begin
                v = $urandom;
            end
            add_item(v, n == N_RANDOM / 2);
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (re_pending.size() != 0 || i_in_valid || drag_expected.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0 && drag_expected.size() == 0) begin
            $display("log_log_table_interpolator_unit regression: pass");
        end else begin
            $display("log_log_table_interpolator_unit regression: fail");
        end
        $finish;
    end

endmodule

>>> log_log_table_interpolator_unit.f
design/llti_pkg.sv
design/llti_div.sv
design/log_log_table_interpolator_unit.sv
design/llti_checker.sv
test/tb_log_log_table_interpolator_unit.sv
